/* rtl/shelf_atlas_rect_allocator_top_macros.svh */
// ----------------------------------------------------------------------------
// Shelf atlas allocator assertion macros
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SHELF_ATLAS_RECT_ALLOCATOR_TOP_MACROS_SVH
`define SHELF_ATLAS_RECT_ALLOCATOR_TOP_MACROS_SVH

// Assertion on clk, disabled while rst_n is low
`define SARL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold on a clock edge out of reset
`define SARL_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/sarl_pkg.sv */
// ----------------------------------------------------------------------------
// sarl_pkg
// Shared constants, codes, types and padding function of the atlas allocator.
// ----------------------------------------------------------------------------
package sarl_pkg;

    localparam int ATLAS_SIZE = 1024;
    localparam int MAX_PAGES  = 8;
    localparam int MAX_FREE   = 16;

    localparam int PG_W   = 3;
    localparam int IDX_W  = 4;
    localparam int FC_W   = 5;
    localparam int DIM_W  = 10;
    localparam int SD_W   = 11;   // padded slot dimension
    localparam int CX_W   = 11;
    localparam int CY_W   = 12;
    localparam int RH_W   = 11;
    localparam int CFG_W  = 11;
    localparam int ADDR_W = PG_W + IDX_W;

    localparam logic [CY_W-1:0] CURSOR_Y_MAX = 12'hFFF;

    // Function codes
    localparam logic [1:0] FN_ACQUIRE = 2'd0;
    localparam logic [1:0] FN_RELEASE = 2'd1;
    localparam logic [1:0] FN_RESET   = 2'd2;

    localparam logic [1:0] FMT_YUV = 2'd2;

    // Status codes
    localparam logic [2:0] ST_REUSED     = 3'd0;
    localparam logic [2:0] ST_BUMPED     = 3'd1;
    localparam logic [2:0] ST_NEW_PAGE   = 3'd2;
    localparam logic [2:0] ST_RELEASED   = 3'd3;
    localparam logic [2:0] ST_IGNORED    = 3'd4;
    localparam logic [2:0] ST_PAGES_FULL = 3'd5;
    localparam logic [2:0] ST_RESET_DONE = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_HOME_COL   = 2'd0;
    localparam logic [1:0] CFG_HOME_ROW   = 2'd1;
    localparam logic [1:0] CFG_HOME_SHELF = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [SD_W-1:0]  w;
        logic [SD_W-1:0]  h;
    } slot_t;

    typedef struct packed {
        logic [PG_W-1:0]  page;
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [2:0]       status;
    } res_t;

    typedef struct packed {
        logic [CFG_W-1:0] home_col;
        logic [CFG_W-1:0] home_row;
        logic [CFG_W-1:0] home_shelf;
    } cfg_t;

    // Slot padding: planar YUV rounds up to even and adds 2, others add 1
    function automatic logic [SD_W-1:0] pad_dim(input logic [1:0] fmt,
                                                 input logic [DIM_W-1:0] v);
        logic [SD_W-1:0] ve;
        ve = {1'b0, v} + 11'd1;
        if (fmt == FMT_YUV)
            return (ve & ~11'd1) + 11'd2;
        return ve;
    endfunction

endpackage

/* rtl/sarl_slot_ram.sv */
// ----------------------------------------------------------------------------
// sarl_slot_ram
// Free slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sarl_slot_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [sarl_pkg::ADDR_W-1:0] waddr,
    input  sarl_pkg::slot_t            wdata,
    input  logic [sarl_pkg::ADDR_W-1:0] raddr,
    output sarl_pkg::slot_t            rdata
);
    import sarl_pkg::*;

    slot_t mem [0:MAX_PAGES*MAX_FREE-1];
    slot_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sarl_engine.sv */
// ----------------------------------------------------------------------------
// sarl_engine
// Page table, free list walk, shelf bump and page open sequencer.
// ----------------------------------------------------------------------------
module sarl_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 func,
    input  logic [1:0]                 pix_format,
    input  logic                       opaque,
    input  logic [sarl_pkg::DIM_W-1:0] width,
    input  logic [sarl_pkg::DIM_W-1:0] height,
    input  logic [sarl_pkg::PG_W-1:0]  page_in,
    input  logic [sarl_pkg::DIM_W-1:0] x_in,
    input  logic [sarl_pkg::DIM_W-1:0] y_in,
    input  sarl_pkg::cfg_t             cfg,
    output logic                       res_valid,
    input  logic                       res_ready,
    output sarl_pkg::res_t             res
);
    import sarl_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_CHK    = 3'd3;
    localparam logic [2:0] S_MOVE   = 3'd4;
    localparam logic [2:0] S_BUMP   = 3'd5;
    localparam logic [2:0] S_NEW    = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    localparam logic [PG_W-1:0]  LAST_PG  = PG_W'(MAX_PAGES - 1);
    localparam logic [CX_W:0]    ATLAS_X  = (CX_W+1)'(ATLAS_SIZE);
    localparam logic [CY_W:0]    ATLAS_Y  = (CY_W+1)'(ATLAS_SIZE);
    localparam logic [FC_W-1:0]  FC_FULL  = FC_W'(MAX_FREE);

    logic [2:0]       state_reg;
    logic [1:0]       func_reg;
    logic [1:0]       fmt_reg;
    logic             opq_reg;
    logic [DIM_W-1:0] w_reg;
    logic [DIM_W-1:0] h_reg;
    logic [SD_W-1:0]  sw_reg;
    logic [SD_W-1:0]  sh_reg;
    logic [PG_W-1:0]  pgin_reg;
    logic [DIM_W-1:0] xin_reg;
    logic [DIM_W-1:0] yin_reg;
    logic [PG_W-1:0]  pg_reg;
    logic [FC_W-1:0]  idx_reg;
    res_t             res_reg;

    // Page table
    logic             pv_reg [MAX_PAGES];
    logic [1:0]       pf_reg [MAX_PAGES];
    logic             po_reg [MAX_PAGES];
    logic [CX_W-1:0]  cx_reg [MAX_PAGES];
    logic [CY_W-1:0]  cy_reg [MAX_PAGES];
    logic [RH_W-1:0]  rh_reg [MAX_PAGES];
    logic [FC_W-1:0]  fc_reg [MAX_PAGES];

    // Slot store ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    slot_t             ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    slot_t             ram_rdata;

    sarl_slot_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Current page view
    logic            cur_match;
    logic [FC_W-1:0] cur_fc;
    logic [FC_W-1:0] last_idx;
    logic            scan_hit;
    logic            slot_fits;

    assign cur_match = pv_reg[pg_reg] && (pf_reg[pg_reg] == fmt_reg)
                       && (po_reg[pg_reg] == opq_reg);
    assign cur_fc    = fc_reg[pg_reg];
    assign last_idx  = cur_fc - 5'd1;
    assign scan_hit  = cur_match && (idx_reg < cur_fc);
    assign slot_fits = (ram_rdata.w >= sw_reg) && (ram_rdata.h >= sh_reg);

    // Shelf bump arithmetic for the current page
    logic [CX_W:0]   sum_x;
    logic            wrap;
    logic [CY_W:0]   sum_y;
    logic [CX_W-1:0] ncx;
    logic [CY_W-1:0] ncy;
    logic [RH_W-1:0] nrh;
    logic            fit_y;

    always_comb
    begin
        sum_x = {1'b0, cx_reg[pg_reg]} + {1'b0, sw_reg};
        wrap  = sum_x > ATLAS_X;
        sum_y = {1'b0, cy_reg[pg_reg]} + {2'b00, rh_reg[pg_reg]};
        ncx   = wrap ? '0 : cx_reg[pg_reg];
        nrh   = wrap ? '0 : rh_reg[pg_reg];
        if (!wrap)
            ncy = cy_reg[pg_reg];
        else if (sum_y > {1'b0, CURSOR_Y_MAX})
            ncy = CURSOR_Y_MAX;
        else
            ncy = sum_y[CY_W-1:0];
        fit_y = ({1'b0, ncy} + {2'b00, sh_reg}) <= ATLAS_Y;
    end

    // Lowest invalid page
    logic            any_free;
    logic [PG_W-1:0] free_pg;

    always_comb
    begin
        any_free = 1'b0;
        free_pg  = '0;
        for (int i = MAX_PAGES - 1; i >= 0; i--)
        begin
            if (!pv_reg[i])
            begin
                any_free = 1'b1;
                free_pg  = PG_W'(i);
            end
        end
    end

    // Release check
    logic rel_ok;
    assign rel_ok = pv_reg[pgin_reg] && (fc_reg[pgin_reg] < FC_FULL);

    // Slot store access
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        unique case (state_reg)
            S_DECODE:
            begin
                if (func_reg == FN_RELEASE && rel_ok)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = {pgin_reg, fc_reg[pgin_reg][IDX_W-1:0]};
                    ram_wdata.x = xin_reg;
                    ram_wdata.y = yin_reg;
                    ram_wdata.w = pad_dim(pf_reg[pgin_reg], w_reg);
                    ram_wdata.h = pad_dim(pf_reg[pgin_reg], h_reg);
                end
            end
            S_SCAN:  ram_raddr = {pg_reg, idx_reg[IDX_W-1:0]};
            S_CHK:   ram_raddr = {pg_reg, last_idx[IDX_W-1:0]};
            S_MOVE:
            begin
                // last entry fills the hole left by the reused slot
                ram_we    = 1'b1;
                ram_waddr = {pg_reg, idx_reg[IDX_W-1:0]};
                ram_wdata = ram_rdata;
            end
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

    // Sequencer and page table update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pg_reg    <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < MAX_PAGES; i++)
            begin
                pv_reg[i] <= 1'b0;
                pf_reg[i] <= '0;
                po_reg[i] <= 1'b0;
                cx_reg[i] <= '0;
                cy_reg[i] <= '0;
                rh_reg[i] <= '0;
                fc_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg  <= func;
                        fmt_reg   <= pix_format;
                        opq_reg   <= opaque;
                        w_reg     <= width;
                        h_reg     <= height;
                        sw_reg    <= pad_dim(pix_format, width);
                        sh_reg    <= pad_dim(pix_format, height);
                        pgin_reg  <= page_in;
                        xin_reg   <= x_in;
                        yin_reg   <= y_in;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    unique case (func_reg)
                        FN_ACQUIRE:
                        begin
                            res_reg   <= '0;
                            pg_reg    <= '0;
                            idx_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                        FN_RELEASE:
                        begin
                            if (rel_ok)
                            begin
                                fc_reg[pgin_reg] <= fc_reg[pgin_reg] + 5'd1;
                                res_reg <= '{page: '0, x: '0, y: '0, status: ST_RELEASED};
                            end
                            else
                                res_reg <= '{page: '0, x: '0, y: '0, status: ST_IGNORED};
                            state_reg <= S_EMIT;
                        end
                        FN_RESET:
                        begin
                            for (int i = 0; i < MAX_PAGES; i++)
                            begin
                                if (pv_reg[i])
                                begin
                                    cx_reg[i] <= cfg.home_col;
                                    cy_reg[i] <= {1'b0, cfg.home_row};
                                    rh_reg[i] <= cfg.home_shelf;
                                    fc_reg[i] <= '0;
                                end
                            end
                            res_reg   <= '{page: '0, x: '0, y: '0, status: ST_RESET_DONE};
                            state_reg <= S_EMIT;
                        end
                        default:
                        begin
                            res_reg   <= '{page: '0, x: '0, y: '0, status: ST_IGNORED};
                            state_reg <= S_EMIT;
                        end
                    endcase
                end
                S_SCAN:
                begin
                    // issue a read of the next free entry, or move on
                    if (scan_hit)
                        state_reg <= S_CHK;
                    else if (pg_reg == LAST_PG)
                    begin
                        pg_reg    <= '0;
                        state_reg <= S_BUMP;
                    end
                    else
                    begin
                        pg_reg  <= pg_reg + 3'd1;
                        idx_reg <= '0;
                    end
                end
                S_CHK:
                begin
                    if (slot_fits)
                    begin
                        fc_reg[pg_reg] <= last_idx;
                        res_reg.page   <= pg_reg;
                        res_reg.x      <= ram_rdata.x;
                        res_reg.y      <= ram_rdata.y;
                        res_reg.status <= ST_REUSED;
                        state_reg      <= (idx_reg == last_idx) ? S_EMIT : S_MOVE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 5'd1;
                        state_reg <= S_SCAN;
                    end
                end
                S_MOVE:
                    state_reg <= S_EMIT;
                S_BUMP:
                begin
                    if (cur_match)
                    begin
                        cy_reg[pg_reg] <= ncy;
                        if (fit_y)
                        begin
                            cx_reg[pg_reg] <= ncx + sw_reg;
                            rh_reg[pg_reg] <= (sh_reg > nrh) ? sh_reg : nrh;
                        end
                        else
                        begin
                            cx_reg[pg_reg] <= ncx;
                            rh_reg[pg_reg] <= nrh;
                        end
                    end
                    if (cur_match && fit_y)
                    begin
                        res_reg.page   <= pg_reg;
                        res_reg.x      <= ncx[DIM_W-1:0];
                        res_reg.y      <= ncy[DIM_W-1:0];
                        res_reg.status <= ST_BUMPED;
                        state_reg      <= S_EMIT;
                    end
                    else if (pg_reg == LAST_PG)
                        state_reg <= S_NEW;
                    else
                        pg_reg <= pg_reg + 3'd1;
                end
                S_NEW:
                begin
                    if (any_free)
                    begin
                        pv_reg[free_pg] <= 1'b1;
                        pf_reg[free_pg] <= fmt_reg;
                        po_reg[free_pg] <= opq_reg;
                        cx_reg[free_pg] <= sw_reg;
                        cy_reg[free_pg] <= '0;
                        rh_reg[free_pg] <= sh_reg;
                        fc_reg[free_pg] <= '0;
                        res_reg.page    <= free_pg;
                        res_reg.status  <= ST_NEW_PAGE;
                    end
                    else
                        res_reg.status <= ST_PAGES_FULL;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (res_ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/shelf_atlas_rect_allocator_top.sv */
// ----------------------------------------------------------------------------
// shelf_atlas_rect_allocator_top
// Shelf rectangle allocator over eight square atlas pages.
// ----------------------------------------------------------------------------
// One item is in work at a time. A release, reset or unused code goes from
// decode straight to the result. An acquire walks the free lists page by page,
// examining the free entries of matching pages (each read from the slot memory,
// then checked; a reused slot that is not the last of its list is replaced by
// the last entry). If no free slot fits, it tries up to 8 pages with the shelf
// cursor pass, one page per cycle, and if none fits, opens a page. The result
// register lets the next item transfer while a result still waits at the output.
module shelf_atlas_rect_allocator_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 func,
    input  logic [1:0]                 pix_format,
    input  logic                       opaque,
    input  logic [sarl_pkg::DIM_W-1:0] width,
    input  logic [sarl_pkg::DIM_W-1:0] height,
    input  logic [sarl_pkg::PG_W-1:0]  page_in,
    input  logic [sarl_pkg::DIM_W-1:0] x_in,
    input  logic [sarl_pkg::DIM_W-1:0] y_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [sarl_pkg::PG_W-1:0]  page_out,
    output logic [sarl_pkg::DIM_W-1:0] x_out,
    output logic [sarl_pkg::DIM_W-1:0] y_out,
    output logic [2:0]                 status,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [sarl_pkg::CFG_W-1:0] cfg_data
);
    import sarl_pkg::*;

    cfg_t cfg_reg;
    logic out_valid_reg;
    res_t out_reg;
    logic res_valid;
    logic res_ready;
    res_t res;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HOME_COL:   cfg_reg.home_col   <= cfg_data;
                CFG_HOME_ROW:   cfg_reg.home_row   <= cfg_data;
                CFG_HOME_SHELF: cfg_reg.home_shelf <= cfg_data;
                default: ;
            endcase
        end
    end

    sarl_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .pix_format (pix_format),
        .opaque     (opaque),
        .width      (width),
        .height     (height),
        .page_in    (page_in),
        .x_in       (x_in),
        .y_in       (y_in),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid && res_ready)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign page_out  = out_reg.page;
    assign x_out     = out_reg.x;
    assign y_out     = out_reg.y;
    assign status    = out_reg.status;

endmodule

/* rtl/sarl_checker.sv */
// ----------------------------------------------------------------------------
// sarl_checker
// Port level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "shelf_atlas_rect_allocator_top_macros.svh"

module sarl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] page_out,
    input logic [9:0] x_out,
    input logic [9:0] y_out,
    input logic [2:0] status
);
    import sarl_pkg::*;

    logic no_grant;
    logic coord_zero;

    // Statuses that grant no slot
    assign no_grant   = (status == ST_RELEASED) || (status == ST_IGNORED)
                        || (status == ST_PAGES_FULL) || (status == ST_RESET_DONE);
    assign coord_zero = (page_out == 3'd0) && (x_out == 10'd0) && (y_out == 10'd0);

    // A stalled result stays
    `SARL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

    // Non-grant results carry no coordinates
    `SARL_ASSERT(a_nogrant_zero, out_valid && no_grant |-> coord_zero, "non-grant with coordinates")

    // No status code beyond the defined set
    `SARL_NEVER(a_status_range, out_valid && status == 3'd7, "undefined status")

    // One item in work: no transfer in the cycle after a transfer
    `SARL_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second item taken while busy")

endmodule

bind shelf_atlas_rect_allocator_top sarl_checker u_sarl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .page_out  (page_out),
    .x_out     (x_out),
    .y_out     (y_out),
    .status    (status)
);

/* sim/shelf_atlas_rect_allocator_top_test.sv */
// ----------------------------------------------------------------------------
// Shelf atlas allocator testbench
// Drives acquire, release and reset requests over valid/ready, predicts each
// grant from a behavioral copy of the page table and free lists, and checks
// every result field by field across register settings and stall patterns.
// ----------------------------------------------------------------------------
module shelf_atlas_rect_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sarl_pkg::*;

    localparam logic [1:0] FN_UNUSED  = 2'd3;
    localparam int         SETTLE     = 320;      // worst acquire walk plus margin
    localparam int         CYCLE_CAP  = 1500000;
    localparam int         RAND_ITEMS = 1230;
    localparam int         PHASES     = 4;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [1:0]       fn;
        logic [1:0]       fmt;
        logic             opq;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [PG_W-1:0]  pg;
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        bit               typed;
        res_t             want;
    } alloc_req_t;

    typedef struct {
        int pg;
        int x;
        int y;
        int w;
        int h;
    } grant_t;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
    logic [1:0]       func, pix_format, cfg_index;
    logic             opaque;
    logic [DIM_W-1:0] width, height, x_in, y_in, x_out, y_out;
    logic [PG_W-1:0]  page_in, page_out;
    logic [2:0]       status;
    logic [CFG_W-1:0] cfg_data;

    // typed expectation travels with the payload
    bit   cur_typed;
    res_t cur_want;

    shelf_atlas_rect_allocator_top uut (.*);

    // predictor state
    int  rsv_cx, rsv_cy, rsv_rh;
    bit  pv[MAX_PAGES];
    int  pfmt[MAX_PAGES], popq[MAX_PAGES];
    int  pcx[MAX_PAGES], pcy[MAX_PAGES], prh[MAX_PAGES], fcnt[MAX_PAGES];
    int  fsx[MAX_PAGES][MAX_FREE], fsy[MAX_PAGES][MAX_FREE];
    int  fsw[MAX_PAGES][MAX_FREE], fsh[MAX_PAGES][MAX_FREE];

    res_t       grant_q[$];
    grant_t     held_slots[$];
    alloc_req_t dir_rows[$];
    int         err_count;
    int         status_hits[8];
    int         cycles;
    int         holdoff;
    idle_mode_t mode;

    function automatic int slot_pad(int fmt, int v);
        if (fmt == FMT_YUV)
            return ((v + 1) & ~1) + 2;
        return v + 1;
    endfunction

    function automatic res_t make_res(int pg, int x, int y, logic [2:0] st);
        res_t r;
        r.page = pg[PG_W-1:0];
        r.x = x[DIM_W-1:0];
        r.y = y[DIM_W-1:0];
        r.status = st;
        return r;
    endfunction

    // behavioral allocator: updates page table and returns the grant
    function automatic res_t alloc_predict(alloc_req_t q);
        int sw, sh, ny, pg;
        res_t r;
        if (q.fn == FN_ACQUIRE) begin
            sw = slot_pad(q.fmt, q.w);
            sh = slot_pad(q.fmt, q.h);
            for (int i = 0; i < MAX_PAGES; i++) begin
                if (!pv[i] || pfmt[i] != q.fmt || popq[i] != q.opq)
                    continue;
                for (int j = 0; j < fcnt[i]; j++) begin
                    if (fsw[i][j] >= sw && fsh[i][j] >= sh) begin
                        r = make_res(i, fsx[i][j], fsy[i][j], ST_REUSED);
                        fcnt[i]--;
                        fsx[i][j] = fsx[i][fcnt[i]];
                        fsy[i][j] = fsy[i][fcnt[i]];
                        fsw[i][j] = fsw[i][fcnt[i]];
                        fsh[i][j] = fsh[i][fcnt[i]];
                        return r;
                    end
                end
            end
            for (int i = 0; i < MAX_PAGES; i++) begin
                if (!pv[i] || pfmt[i] != q.fmt || popq[i] != q.opq)
                    continue;
                // wrap to a new shelf, kept even if the slot then fails to fit
                if (pcx[i] + sw > ATLAS_SIZE) begin
                    ny = pcy[i] + prh[i];
                    pcx[i] = 0;
                    pcy[i] = (ny > 4095) ? 4095 : ny;
                    prh[i] = 0;
                end
                if (pcy[i] + sh <= ATLAS_SIZE) begin
                    r = make_res(i, pcx[i], pcy[i], ST_BUMPED);
                    pcx[i] += sw;
                    if (sh > prh[i])
                        prh[i] = sh;
                    return r;
                end
            end
            for (int i = 0; i < MAX_PAGES; i++) begin
                if (!pv[i]) begin
                    pv[i] = 1;
                    pfmt[i] = q.fmt;
                    popq[i] = q.opq;
                    pcx[i] = sw;
                    pcy[i] = 0;
                    prh[i] = sh;
                    fcnt[i] = 0;
                    return make_res(i, 0, 0, ST_NEW_PAGE);
                end
            end
            return make_res(0, 0, 0, ST_PAGES_FULL);
        end
        if (q.fn == FN_RELEASE) begin
            pg = q.pg;
            if (!pv[pg] || fcnt[pg] >= MAX_FREE)
                return make_res(0, 0, 0, ST_IGNORED);
            fsx[pg][fcnt[pg]] = q.x;
            fsy[pg][fcnt[pg]] = q.y;
            fsw[pg][fcnt[pg]] = slot_pad(pfmt[pg], q.w);
            fsh[pg][fcnt[pg]] = slot_pad(pfmt[pg], q.h);
            fcnt[pg]++;
            return make_res(0, 0, 0, ST_RELEASED);
        end
        if (q.fn == FN_RESET) begin
            for (int i = 0; i < MAX_PAGES; i++) begin
                if (!pv[i])
                    continue;
                pcx[i] = rsv_cx;
                pcy[i] = rsv_cy;
                prh[i] = rsv_rh;
                fcnt[i] = 0;
            end
            return make_res(0, 0, 0, ST_RESET_DONE);
        end
        return make_res(0, 0, 0, ST_IGNORED);
    endfunction

    // clock
    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("shelf_atlas_rect_allocator_top_test: done, errors");
            $finish;
        end
    end

    // input and config transfers feed the predictor
    always @(posedge clk) begin
        alloc_req_t q;
        res_t       r;
        grant_t     g;
        if (rst_n && cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HOME_COL:   rsv_cx = cfg_data;
                CFG_HOME_ROW:   rsv_cy = cfg_data;
                CFG_HOME_SHELF: rsv_rh = cfg_data;
                default: ;
            endcase
        end
        if (rst_n && in_valid && in_ready) begin
            q.fn = func; q.fmt = pix_format; q.opq = opaque;
            q.w = width; q.h = height; q.pg = page_in; q.x = x_in; q.y = y_in;
            r = alloc_predict(q);
            if (r.status <= ST_NEW_PAGE) begin
                g.pg = r.page; g.x = r.x; g.y = r.y; g.w = width; g.h = height;
                held_slots.push_back(g);
            end
            grant_q.push_back(cur_typed ? cur_want : r);
        end
    end

    // result checking
    always @(posedge clk) begin
        res_t e;
        if (rst_n && out_valid && out_ready) begin
            if (grant_q.size() == 0) begin
                $error("result with nothing expected: status %0d", status);
                err_count++;
            end else begin
                e = grant_q.pop_front();
                status_hits[status]++;
                if (page_out !== e.page) begin
                    $error("page_out expected %0d actual %0d", e.page, page_out);
                    err_count++;
                end
                if (x_out !== e.x) begin
                    $error("x_out expected %0d actual %0d", e.x, x_out);
                    err_count++;
                end
                if (y_out !== e.y) begin
                    $error("y_out expected %0d actual %0d", e.y, y_out);
                    err_count++;
                end
                if (status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, status);
                    err_count++;
                end
            end
        end
    end

    // receiver: random stalls per phase, plus a long hold-off on request
    always @(posedge clk) begin
        if (holdoff > 0) begin
            holdoff <= holdoff - 1;
            out_ready <= 1'b0;
        end else if (mode == IDLE_RECV)
            out_ready <= ($urandom_range(99) >= 62);
        else if (mode == IDLE_BOTH)
            out_ready <= ($urandom_range(99) >= 10);
        else
            out_ready <= 1'b1;
    end

    task automatic send_req(alloc_req_t q);
        int gap;
        int pct;
        gap = 0;
        pct = (mode == IDLE_SEND) ? 62 : (mode == IDLE_BOTH) ? 10 : 0;
        while (gap < 20 && $urandom_range(99) < pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= q.fn;
        pix_format <= q.fmt;
        opaque     <= q.opq;
        width      <= q.w;
        height     <= q.h;
        page_in    <= q.pg;
        x_in       <= q.x;
        y_in       <= q.y;
        cur_typed  <= q.typed;
        cur_want   <= q.want;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic void add_row(logic [1:0] fn, logic [1:0] fmt, logic opq,
                                    int w, int h, int pg, int x, int y,
                                    bit typed, res_t want);
        alloc_req_t q;
        q.fn = fn; q.fmt = fmt; q.opq = opq; q.w = w; q.h = h;
        q.pg = pg; q.x = x; q.y = y; q.typed = typed; q.want = want;
        dir_rows.push_back(q);
    endfunction

    function automatic alloc_req_t rand_req();
        alloc_req_t q;
        int k, sel;
        grant_t g;
        q.fn = FN_ACQUIRE;
        q.fmt = $urandom_range(3);
        q.opq = $urandom_range(1);
        // mostly small sizes, a few across the whole field
        if ($urandom_range(9) == 0) begin
            q.w = $urandom_range(1023);
            q.h = $urandom_range(1023);
        end else begin
            q.w = $urandom_range(1, 96);
            q.h = $urandom_range(1, 96);
        end
        q.pg = $urandom_range(7);
        q.x = $urandom_range(1023);
        q.y = $urandom_range(1023);
        q.typed = 0;
        q.want = '0;
        k = $urandom_range(99);
        if (k < 40) begin
            q.fn = FN_RELEASE;
            if (held_slots.size() != 0 && $urandom_range(9) != 0) begin
                sel = $urandom_range(held_slots.size() - 1);
                g = held_slots[sel];
                held_slots.delete(sel);
                q.pg = g.pg; q.x = g.x; q.y = g.y; q.w = g.w; q.h = g.h;
            end
        end else if (k < 43)
            q.fn = FN_RESET;
        else if (k < 45)
            q.fn = FN_UNUSED;
        return q;
    endfunction

    initial begin
        logic [CFG_W-1:0] cx, cy, rh;
        rst_n = 0;
        in_valid = 0; cfg_valid = 0; out_ready = 0;
        func = '0; pix_format = '0; opaque = 0; width = '0; height = '0;
        page_in = '0; x_in = '0; y_in = '0; cfg_index = '0; cfg_data = '0;
        cur_typed = 0; cur_want = '0;
        rsv_cx = 0; rsv_cy = 0; rsv_rh = 0;
        err_count = 0; cycles = 0; holdoff = 0; mode = IDLE_NONE;
        for (int i = 0; i < MAX_PAGES; i++) begin
            pv[i] = 0; pfmt[i] = 0; popq[i] = 0; pcx[i] = 0; pcy[i] = 0;
            prh[i] = 0; fcnt[i] = 0;
        end
        for (int i = 0; i < 8; i++)
            status_hits[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, reuse, filling the page table
        add_row(FN_RELEASE, 0, 0, 5, 5, 3, 0, 0, 1, make_res(0, 0, 0, ST_IGNORED));
        add_row(FN_UNUSED, 3, 1, 1023, 1023, 7, 1023, 1023, 1,
                make_res(0, 0, 0, ST_IGNORED));
        add_row(FN_RESET, 0, 0, 1, 1, 0, 0, 0, 1, make_res(0, 0, 0, ST_RESET_DONE));
        add_row(FN_ACQUIRE, 0, 0, 1022, 1022, 0, 0, 0, 1,
                make_res(0, 0, 0, ST_NEW_PAGE));
        add_row(FN_ACQUIRE, 0, 0, 1, 1, 0, 0, 0, 0, '0);
        add_row(FN_ACQUIRE, 2, 1, 1, 1, 0, 0, 0, 1, make_res(2, 0, 0, ST_NEW_PAGE));
        add_row(FN_ACQUIRE, 2, 1, 1023, 1023, 0, 0, 0, 0, '0);
        add_row(FN_ACQUIRE, 3, 0, 0, 0, 0, 0, 0, 0, '0);
        add_row(FN_RELEASE, 3, 1, 1022, 1022, 0, 1023, 1023, 1,
                make_res(0, 0, 0, ST_RELEASED));
        add_row(FN_ACQUIRE, 0, 0, 500, 500, 0, 0, 0, 1,
                make_res(0, 1023, 1023, ST_REUSED));
        add_row(FN_RELEASE, 0, 0, 4, 4, 7, 10, 10, 1, make_res(0, 0, 0, ST_IGNORED));
        add_row(FN_ACQUIRE, 2, 1, 3, 2, 0, 0, 0, 0, '0);
        add_row(FN_ACQUIRE, 2, 1, 1000, 8, 0, 0, 0, 0, '0);
        add_row(FN_ACQUIRE, 1, 0, 700, 300, 0, 0, 0, 0, '0);
        add_row(FN_ACQUIRE, 1, 1, 700, 300, 0, 0, 0, 0, '0);
        add_row(FN_ACQUIRE, 3, 1, 16, 16, 0, 0, 0, 0, '0);
        add_row(FN_ACQUIRE, 0, 1, 16, 16, 0, 0, 0, 0, '0);
        add_row(FN_ACQUIRE, 2, 0, 16, 16, 0, 0, 0, 0, '0);
        add_row(FN_ACQUIRE, 1, 0, 700, 700, 0, 0, 0, 0, '0);
        add_row(FN_RELEASE, 1, 1, 512, 341, 5, 682, 341, 0, '0);
        add_row(FN_RESET, 2, 1, 9, 9, 4, 0, 0, 0, '0);
        foreach (dir_rows[i])
            send_req(dir_rows[i]);
        drain();

        // random phases, each under its own register setting and idle pattern
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin cx = 11'd2047; cy = 11'd2047; rh = 11'd2047; end
                1: begin cx = 11'd0;    cy = 11'd0;    rh = 11'd0;    end
                2: begin cx = 11'd1024; cy = 11'd1000; rh = 11'd1024; end
                default: begin
                    cx = $urandom_range(1024);
                    cy = $urandom_range(1024);
                    rh = $urandom_range(64);
                end
            endcase
            write_reg(CFG_HOME_COL, cx);
            write_reg(CFG_HOME_ROW, cy);
            write_reg(CFG_HOME_SHELF, rh);
            mode = idle_mode_t'(ph);
            if (ph == 0)
                holdoff = 400;
            for (int n = 0; n < RAND_ITEMS / PHASES; n++)
                send_req(rand_req());
            drain();
        end
        mode = IDLE_NONE;

        $display("covered %0d directed and %0d random requests over %0d settings",
                 dir_rows.size(), (RAND_ITEMS / PHASES) * PHASES, PHASES);
        $display("results: reused %0d bumped %0d new %0d released %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 " ignored %0d full %0d reset %0d",
                 status_hits[4], status_hits[5], status_hits[6]);
        if (err_count == 0)
            $display("shelf_atlas_rect_allocator_top_test: done, clean");
        else
            $display("shelf_atlas_rect_allocator_top_test: done, errors");
        $finish;
    end

endmodule
